// ===== src/plist_pkg.sv =====
package plist_pkg;

  localparam int CAPACITY = 256;

  localparam int POS_W   = 8;
  localparam int VAL_W   = 32;
  localparam int OUT_CNT_W = 9;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int GSEL_W  = 4;
  localparam int GRP     = 1 << GSEL_W;
  localparam int GIDX_W  = POS_W - GSEL_W;
  localparam int NGRP    = (CAPACITY + GRP - 1) / GRP;
  localparam int NSEL    = (NGRP < (1 << GIDX_W)) ? NGRP : (1 << GIDX_W);

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_READ   = 2'd0;
  localparam opcode_t OP_INSERT = 2'd1;
  localparam opcode_t OP_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LO,
    CELL_FROM_HI
  } cell_op_t;

endpackage

// ===== src/plist_cell.sv =====
module plist_cell (
  input  logic                  clk,
  input  plist_pkg::cell_op_t   op,
  input  logic signed [31:0]    value,
  input  logic signed [31:0]    lo_q,
  input  logic signed [31:0]    hi_q,
  output logic signed [31:0]    q
);
  import plist_pkg::*;

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;

  always_comb begin
    case (op)
      CELL_HOLD:    data_nxt = data_r;
      CELL_LOAD:    data_nxt = value;
      CELL_FROM_LO: data_nxt = lo_q;
      CELL_FROM_HI: data_nxt = hi_q;
      default:      data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

// ===== src/positional_insert_remove_list_core.sv =====
// Positional insert/remove list: an ordered list of signed 32-bit entries held
// in a row of CAPACITY cells plus an entry count.
// Input channel (in_valid/in_stall): opcode 0 reads at in_position, 1 inserts
// in_value before in_position, 2 removes the entry at in_position.
// Result channel (out_valid/out_stall): one transaction per input transaction,
// in order, carrying out_ok, out_read_value (0 unless a successful read) and
// out_count, the number of entries after the operation.
// Throughput: one transaction per cycle while in_stall is low. Inserts and
// removes shift all cells at or above in_position at once on acceptance.
// Each result passes the select-stage register, then the output register.
// The read select runs as a registered two-level tree: 16:1 within groups
// of cells, then across groups. Reset clears the count and the pipeline
// valids; cell contents stay undefined until written. When the receiver
// stalls, the result holds in the output register, one more transaction waits
// in the select stage, and then in_stall rises until the output is taken.
module positional_insert_remove_list_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic signed [31:0] out_read_value,
  output logic [8:0]         out_count
);
  import plist_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             in_acc;
  logic             adv;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] cnt_c;
  logic             rd_ok;
  logic             ins_ok;
  logic             rem_ok;
  logic             op_ok;

  logic signed [VAL_W-1:0] cell_q [CAPACITY];
  cell_op_t                cell_op [CAPACITY];
  logic signed [VAL_W-1:0] ent_grp [NSEL][GRP];
  logic signed [VAL_W-1:0] grp_nxt [NSEL];

  logic                    s1_valid_r;
  logic                    s1_ok_r;
  logic                    s1_rd_r;
  logic [OUT_CNT_W-1:0]    s1_count_r;
  logic [GIDX_W-1:0]       s1_gidx_r;
  logic signed [VAL_W-1:0] s1_grp_r [NSEL];

  logic                    out_valid_r;
  logic                    out_ok_r;
  logic [OUT_CNT_W-1:0]    out_count_r;
  logic signed [VAL_W-1:0] out_rd_r;
  logic signed [VAL_W-1:0] sel_val;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  assign pos_c  = CMP_W'(in_position);
  assign cnt_c  = CMP_W'(cnt_r);
  assign rd_ok  = (in_opcode == OP_READ) && (pos_c < cnt_c);
  assign ins_ok = (in_opcode == OP_INSERT) && (pos_c <= cnt_c)
                  && (cnt_c < CMP_W'(CAPACITY));
  assign rem_ok = (in_opcode == OP_REMOVE) && (pos_c < cnt_c);
  assign op_ok  = rd_ok || ins_ok || rem_ok;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && ins_ok) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (in_acc && rem_ok) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] lo_q;
    logic signed [VAL_W-1:0] hi_q;

    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (in_acc && ins_ok) begin
        if (CMP_W'(i) == pos_c) begin
          cell_op[i] = CELL_LOAD;
        end else if (CMP_W'(i) > pos_c) begin
          cell_op[i] = CELL_FROM_LO;
        end
      end else if (in_acc && rem_ok && (i < CAPACITY - 1)) begin
        if (CMP_W'(i) >= pos_c) begin
          cell_op[i] = CELL_FROM_HI;
        end
      end
    end

    if (i == 0) begin : g_lo0
      assign lo_q = '0;
    end else begin : g_lo
      assign lo_q = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_hitop
      assign hi_q = '0;
    end else begin : g_hi
      assign hi_q = cell_q[i+1];
    end

    plist_cell u_cell (
      .clk   (clk),
      .op    (cell_op[i]),
      .value (in_value),
      .lo_q  (lo_q),
      .hi_q  (hi_q),
      .q     (cell_q[i])
    );
  end

  for (genvar g = 0; g < NSEL; g++) begin : g_grp
    for (genvar k = 0; k < GRP; k++) begin : g_ent
      if (g * GRP + k < CAPACITY) begin : g_real
        assign ent_grp[g][k] = cell_q[g*GRP+k];
      end else begin : g_pad
        assign ent_grp[g][k] = '0;
      end
    end
    assign grp_nxt[g] = ent_grp[g][in_position[GSEL_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ok_r    <= op_ok;
      s1_rd_r    <= rd_ok;
      s1_count_r <= OUT_CNT_W'(32'(cnt_nxt));
      s1_gidx_r  <= in_position[POS_W-1:GSEL_W];
      for (int g = 0; g < NSEL; g++) begin
        s1_grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    sel_val = '0;
    for (int g = 0; g < NSEL; g++) begin
      if (s1_gidx_r == GIDX_W'(g)) begin
        sel_val = s1_grp_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_ok_r    <= s1_ok_r;
      out_count_r <= s1_count_r;
      out_rd_r    <= s1_rd_r ? sel_val : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_rd_r;
  assign out_count      = out_count_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= CAPACITY)
    else $error("entry count above capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_read_value == '0))
    else $error("failed transaction carries nonzero read value");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ins_ok) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not advance count");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> s1_valid_r)
    else $error("select stage dropped a transaction");

endmodule
